[rtl/sdpg_pkg.sv]
// Package for the step/direction pulse train generator.
// Holds the sizing constants, the action codes and the transaction payload types.
// Has no dependencies; every other file of the block imports it.
package sdpg_pkg;

  localparam int COUNTER_WIDTH    = 16;
  localparam int STEP_COUNT_WIDTH = 32;

  // Timer input clock in hertz and the bits needed to hold it.
  localparam int TIMER_CLOCK_HZ = 180000000;
  localparam int DIVD_W         = $clog2(TIMER_CLOCK_HZ + 1);
  localparam int IDX_W          = $clog2(DIVD_W);
  localparam int PROD_W         = 49;

  localparam logic [31:0] CNT_MAX = 32'((64'(1) << COUNTER_WIDTH) - 64'(1));

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_FREQ  = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam logic [15:0] PRESCALER_RESET = 16'd215;
  localparam logic [COUNTER_WIDTH-1:0] PERIOD_RESET  = COUNTER_WIDTH'(9);
  localparam logic [COUNTER_WIDTH-1:0] COMPARE_RESET = COUNTER_WIDTH'(4);

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        step_count;
    logic               direction;
    logic signed [31:0] frequency_hz;
  } in_item_t;

  typedef struct packed {
    logic        pulse_level;
    logic        direction_level;
    logic        busy_res;
    logic [31:0] steps_left;
    logic        run_finished;
  } out_item_t;

  typedef struct packed {
    logic [COUNTER_WIDTH-1:0] period;
    logic [COUNTER_WIDTH-1:0] compare;
  } timing_t;

endpackage

[rtl/sdpg_in_if.sv]
// Input channel of the step/direction pulse train generator.
// Carries valid, ready and one input item; depends on sdpg_pkg.
interface sdpg_in_if;
  import sdpg_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sdpg_out_if.sv]
// Result channel of the step/direction pulse train generator.
// Carries valid, ready and one result item; depends on sdpg_pkg.
interface sdpg_out_if;
  import sdpg_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sdpg_period_calc.sv]
// Period and compare calculation: one multiply, a range check, then a restoring
// divider that reuses a single subtract/compare stage for one quotient bit per cycle.
// Depends on sdpg_pkg.
module sdpg_period_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        prescaler,
  input  logic [31:0]        freq_mag,
  output logic               done,
  output sdpg_pkg::timing_t  result
);
  import sdpg_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MUL  = 3'd1;
  localparam logic [2:0] C_CHK  = 3'd2;
  localparam logic [2:0] C_DIV  = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  localparam logic [DIVD_W-1:0] HZ_BITS = DIVD_W'(TIMER_CLOCK_HZ);

  logic [2:0]        state_r, state_nxt;
  logic [16:0]       psc_r;
  logic [31:0]       fmag_r;
  logic [PROD_W-1:0] denom_r;
  logic [DIVD_W-1:0] div_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [IDX_W-1:0]  idx_r;
  logic              done_r;
  timing_t           result_r;

  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;
  logic              fits;
  logic [31:0]       per;
  logic [31:0]       per_sat;

  // The one shared stage: shift in the next dividend bit, compare, subtract.
  always_comb begin
    trial = {rem_r, HZ_BITS[idx_r]};
    diff  = trial - {1'b0, div_r};
    fits  = (trial >= {1'b0, div_r});
  end

  always_comb begin
    per     = (quo_r == '0) ? 32'd0 : 32'(quo_r) - 32'd1;
    per_sat = (per > CNT_MAX) ? CNT_MAX : per;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (start) state_nxt = C_MUL;
      C_MUL:  state_nxt = C_CHK;
      C_CHK:  state_nxt = (denom_r > PROD_W'(TIMER_CLOCK_HZ)) ? C_FIN : C_DIV;
      C_DIV:  if (idx_r == '0) state_nxt = C_FIN;
      C_FIN:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        psc_r  <= {1'b0, prescaler} + 17'd1;
        fmag_r <= freq_mag;
      end
      C_MUL: begin
        denom_r <= PROD_W'(psc_r) * PROD_W'(fmag_r);
      end
      C_CHK: begin
        div_r <= denom_r[DIVD_W-1:0];
        rem_r <= '0;
        quo_r <= '0;
        idx_r <= IDX_W'(DIVD_W - 1);
      end
      C_DIV: begin
        rem_r <= fits ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], fits};
        idx_r <= idx_r - IDX_W'(1);
      end
      C_FIN: begin
        result_r.period  <= per_sat[COUNTER_WIDTH-1:0];
        result_r.compare <= per_sat[COUNTER_WIDTH:1];
      end
      default: begin
      end
    endcase
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

[rtl/step_dir_pulse_train_generator.sv]
// Step/direction pulse train generator, top level.
// Holds the timer, run and direction state and the result register; uses
// sdpg_pkg, sdpg_in_if, sdpg_out_if and sdpg_period_calc.
//
// Each input transaction produces exactly one result transaction that shows
// the state after it. Tick, start and forced-stop transactions are handled
// directly, so ticks can be fed on every clock while each result is taken as
// soon as it is offered. A set-frequency transaction with a nonzero rate goes
// through the period calculation after it is taken. The operands are latched
// at the accepting edge. Then come the (prescaler+1)*f multiply, a range check,
// the shared one-bit-per-cycle divider, a step to saturate and halve the result
// and one to hand it back. When (prescaler+1)*f already exceeds the timer
// clock, the divider is skipped and the period is zero. The input is not
// ready while the calculation runs. A rate of zero only halts the pulse
// output and completes without the divider. The result register holds one
// result; a new input transaction is taken only when that register is empty
// or its result leaves in the same cycle, so a waiting result holds off the input.
// The prescaler register is written through cfg_we/cfg_wdata and must only be
// changed while no transaction is in flight.
module step_dir_pulse_train_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  sdpg_in_if.sink     in_ch,
  sdpg_out_if.source  out_ch
);
  import sdpg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic                        state_r, state_nxt;
  logic [15:0]                 prescaler_r;
  logic [COUNTER_WIDTH-1:0]    counter_r, counter_nxt;
  logic [COUNTER_WIDTH-1:0]    period_r, period_nxt;
  logic [COUNTER_WIDTH-1:0]    compare_r, compare_nxt;
  logic [STEP_COUNT_WIDTH-1:0] remaining_r, remaining_nxt;
  logic                        busy_r, busy_nxt;
  logic                        enabled_r, enabled_nxt;
  logic                        dir_r, dir_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_data_r;

  logic                        in_fire;
  logic                        load_out;
  logic                        finished;
  logic                        calc_start;
  logic                        calc_done;
  timing_t                     calc_res;
  logic [31:0]                 f_mag;
  logic [STEP_COUNT_WIDTH-1:0] count;
  logic [STEP_COUNT_WIDTH-1:0] rem_dec;
  out_item_t                   out_nxt;

  // A new transaction is taken when no division runs and the result
  // register is empty or being emptied in the same cycle.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Magnitude of the signed rate; the most negative value maps to 2^31.
  assign f_mag = in_ch.data.frequency_hz[31] ?
                 (~$unsigned(in_ch.data.frequency_hz) + 32'd1) :
                 $unsigned(in_ch.data.frequency_hz);
  assign count   = in_ch.data.step_count[STEP_COUNT_WIDTH-1:0];
  assign rem_dec = (remaining_r != '0) ? remaining_r - STEP_COUNT_WIDTH'(1) : remaining_r;

  always_comb begin
    state_nxt     = state_r;
    counter_nxt   = counter_r;
    period_nxt    = period_r;
    compare_nxt   = compare_r;
    remaining_nxt = remaining_r;
    busy_nxt      = busy_r;
    enabled_nxt   = enabled_r;
    dir_nxt       = dir_r;
    finished      = 1'b0;
    load_out      = 1'b0;
    calc_start    = 1'b0;

    if (state_r == ST_CALC) begin
      if (calc_done) begin
        period_nxt  = calc_res.period;
        compare_nxt = calc_res.compare;
        load_out    = 1'b1;
        state_nxt   = ST_IDLE;
      end
    end else if (in_fire) begin
      load_out = 1'b1;
      case (in_ch.data.action)
        ACT_TICK: begin
          // A compare match uses up one pulse; the last one ends the run.
          if (enabled_r && (counter_r == compare_r)) begin
            remaining_nxt = rem_dec;
            if (rem_dec == '0) begin
              enabled_nxt = 1'b0;
              busy_nxt    = 1'b0;
              finished    = 1'b1;
            end
          end
          counter_nxt = (counter_r >= period_r) ? '0 : counter_r + COUNTER_WIDTH'(1);
        end
        ACT_START: begin
          if ((count != '0) && !busy_r) begin
            busy_nxt      = 1'b1;
            remaining_nxt = count;
            dir_nxt       = in_ch.data.direction;
            enabled_nxt   = 1'b1;
          end
        end
        ACT_FREQ: begin
          // A zero rate only halts the output; busy stays set.
          if (f_mag == 32'd0) begin
            enabled_nxt = 1'b0;
          end else begin
            load_out   = 1'b0;
            calc_start = 1'b1;
            state_nxt  = ST_CALC;
          end
        end
        default: begin
          enabled_nxt   = 1'b0;
          remaining_nxt = '0;
          busy_nxt      = 1'b0;
        end
      endcase
    end
  end

  // The result always reflects the state after the transaction.
  always_comb begin
    out_nxt.pulse_level     = enabled_nxt && (counter_nxt < compare_nxt);
    out_nxt.direction_level = dir_nxt;
    out_nxt.busy_res        = busy_nxt;
    out_nxt.steps_left      = 32'(remaining_nxt);
    out_nxt.run_finished    = finished;
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prescaler_r <= PRESCALER_RESET;
      counter_r   <= '0;
      period_r    <= PERIOD_RESET;
      compare_r   <= COMPARE_RESET;
      remaining_r <= '0;
      busy_r      <= 1'b0;
      enabled_r   <= 1'b0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        prescaler_r <= cfg_wdata;
      end
      counter_r   <= counter_nxt;
      period_r    <= period_nxt;
      compare_r   <= compare_nxt;
      remaining_r <= remaining_nxt;
      busy_r      <= busy_nxt;
      enabled_r   <= enabled_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  sdpg_period_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (calc_start),
    .prescaler (prescaler_r),
    .freq_mag  (f_mag),
    .done      (calc_done),
    .result    (calc_res)
  );

endmodule

[test/tb.sv]
// Self-checking testbench for step_dir_pulse_train_generator.
// Uses sdpg_pkg, sdpg_in_if, sdpg_out_if and the generator RTL. It drives ticks, starts,
// frequency settings and forced stops, and predicts every result transaction.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdpg_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 160;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  sdpg_in_if  in_bus ();
  sdpg_out_if out_bus ();

  step_dir_pulse_train_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // Items waiting to be offered, and the pin states predicted for the
  // transactions that the block has already taken.
  in_item_t  action_q[$];
  out_item_t pin_states[$];

  int errors = 0;

  // Idling controls, changed by the stimulus only at a falling edge.
  bit src_idle    = 1'b0;
  bit snk_idle    = 1'b0;
  int hold_tokens = 0;

  // Our own copy of the generator state, at reset values.
  logic [15:0]              psc       = PRESCALER_RESET;
  logic [COUNTER_WIDTH-1:0] tmr_cnt   = '0;
  logic [COUNTER_WIDTH-1:0] tmr_per   = PERIOD_RESET;
  logic [COUNTER_WIDTH-1:0] tmr_cmp   = COMPARE_RESET;
  logic [31:0]              steps_rem = '0;
  logic                     run_busy  = 1'b0;
  logic                     pulse_en  = 1'b0;
  logic                     dir_lvl   = 1'b0;

  // Clock, and every block input at a known value from time zero.
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one input item to the generator state and returns the pins and
  // status that the block must show afterwards.
  function automatic out_item_t advance_timer(in_item_t it);
    out_item_t        r;
    logic [31:0]      f;
    longint unsigned  q;
    longint unsigned  per;
    logic             done;
    done = 1'b0;
    case (it.action)
      ACT_TICK: begin
        // A compare match uses up one pulse; the last one ends the run.
        if (pulse_en && tmr_cnt == tmr_cmp) begin
          if (steps_rem != 0) steps_rem = steps_rem - 1;
          if (steps_rem == 0) begin
            pulse_en = 1'b0;
            run_busy = 1'b0;
            done     = 1'b1;
          end
        end
        // The counter wraps after the period value, also when it already
        // sits above a period that was just made smaller.
        if (tmr_cnt >= tmr_per) tmr_cnt = '0;
        else tmr_cnt = tmr_cnt + 1'b1;
      end
      ACT_START: begin
        if (it.step_count != 0 && !run_busy) begin
          run_busy  = 1'b1;
          steps_rem = it.step_count;
          dir_lvl   = it.direction;
          pulse_en  = 1'b1;
        end
      end
      ACT_FREQ: begin
        // The sign is dropped; the most negative value stays 2^31.
        f = it.frequency_hz;
        if (f[31]) f = 32'd0 - f;
        if (f == 0) begin
          // Zero only halts the output, the run stays busy.
          pulse_en = 1'b0;
        end else begin
          q   = 64'(TIMER_CLOCK_HZ) / ((64'(psc) + 64'd1) * 64'(f));
          per = (q == 0) ? 64'd0 : q - 64'd1;
          if (per > 64'(CNT_MAX)) per = 64'(CNT_MAX);
          tmr_per = per[COUNTER_WIDTH-1:0];
          tmr_cmp = tmr_per >> 1;
        end
      end
      ACT_STOP: begin
        pulse_en  = 1'b0;
        steps_rem = '0;
        run_busy  = 1'b0;
      end
    endcase
    r.pulse_level     = pulse_en && (tmr_cnt < tmr_cmp);
    r.direction_level = dir_lvl;
    r.busy_res        = run_busy;
    r.steps_left      = steps_rem;
    r.run_finished    = done;
    return r;
  endfunction

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_pins(out_item_t got);
    out_item_t want;
    if (pin_states.size() == 0) begin
      errors++;
      $display("%0t: result transaction with nothing expected, expected none, actual %p",
               $time, got);
      return;
    end
    want = pin_states.pop_front();
    cmp_field("pulse_level", want.pulse_level, got.pulse_level);
    cmp_field("direction_level", want.direction_level, got.direction_level);
    cmp_field("busy_res", want.busy_res, got.busy_res);
    cmp_field("steps_left", want.steps_left, got.steps_left);
    cmp_field("run_finished", want.run_finished, got.run_finished);
  endtask

  // Driver: offers the queued items one by one. After each item it waits
  // the gap drawn for that item before offering the next one. The state is
  // predicted at the edge where the transaction is accepted.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        pin_states.push_back(advance_timer(in_bus.data));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (action_q.size() > 0) begin
          in_bus.data  <= action_q.pop_front();
          in_bus.valid <= 1'b1;
          send_gap = src_idle ? $urandom_range(0, 11) : 0;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and then stalls for a drawn
  // number of cycles. A hold-off request from the stimulus makes it refuse
  // results for a long stretch so that the block backs up into its input.
  int recv_gap   = 0;
  int hold_left  = 0;
  int hold_taken = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_pins(out_bus.data);
        recv_gap = snk_idle ? $urandom_range(0, 11) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_taken != hold_tokens) begin
        hold_taken++;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mk_item(logic [1:0] act, logic [31:0] count, logic dir,
                                       logic [31:0] freq);
    in_item_t it;
    it.action       = act;
    it.step_count   = count;
    it.direction    = dir;
    it.frequency_hz = freq;
    return it;
  endfunction

  // Fields that the action ignores still carry random bits.
  function automatic in_item_t rand_item(logic [1:0] act);
    return mk_item(act, $urandom, 1'($urandom_range(0, 1)), $urandom);
  endfunction

  // A rate that gives roughly the wanted period at the current prescaler,
  // with a random sign.
  function automatic logic [31:0] rate_for(int p);
    longint unsigned f;
    logic [31:0]     r;
    f = 64'(TIMER_CLOCK_HZ) / ((64'(psc) + 64'd1) * 64'(p + 1));
    if (f == 0) f = 1;
    r = f[31:0];
    if ($urandom_range(0, 1)) r = 32'd0 - r;
    return r;
  endfunction

  // One run: optional stop, an optional rate, a start and up to 48 ticks meant to finish it,
  // with the odd disturbance in between. Some episodes are plain noise.
  task automatic queue_episode();
    int          p;
    logic [31:0] count;
    longint      n_tick;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 4)) action_q.push_back(rand_item(2'($urandom_range(0, 3))));
      return;
    end
    if ($urandom_range(0, 99) < 35) action_q.push_back(rand_item(ACT_STOP));
    p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    if ($urandom_range(0, 4) != 0) begin
      action_q.push_back(mk_item(ACT_FREQ, $urandom, 1'($urandom_range(0, 1)), rate_for(p)));
    end
    count = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) count = '0;
    action_q.push_back(mk_item(ACT_START, count, 1'($urandom_range(0, 1)), $urandom));
    n_tick = longint'(count) * (p + 1) + $urandom_range(0, 4);
    if (n_tick > 48) n_tick = 48;
    for (longint k = 0; k < n_tick; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
        action_q.push_back(rand_item(ACT_STOP));
      end else if (roll < 2) begin
        action_q.push_back(mk_item(ACT_START, $urandom_range(1, 5),
                                   1'($urandom_range(0, 1)), $urandom));
      end else if (roll < 3) begin
        action_q.push_back(mk_item(ACT_FREQ, $urandom, 1'($urandom_range(0, 1)), 32'd0));
      end else if (roll < 4) begin
        action_q.push_back(mk_item(ACT_FREQ, $urandom, 1'($urandom_range(0, 1)),
                                   rate_for($urandom_range(0, 6))));
      end
      action_q.push_back(rand_item(ACT_TICK));
    end
  endtask

  task automatic queue_phase(int n, bit src_on, bit snk_on, bit hold_on);
    int target;
    @(negedge clk);
    src_idle = src_on;
    snk_idle = snk_on;
    if (hold_on) hold_tokens++;
    target = action_q.size() + n;
    while (action_q.size() < target) queue_episode();
  endtask

  // Waits until every queued item was accepted and every result arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (action_q.size() != 0 || in_bus.valid || pin_states.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // The prescaler only changes between phases, with nothing in flight.
  task automatic write_prescaler(logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    psc = v;
  endtask

  // Directed part at the reset prescaler of 215, where 180 MHz / 216 is
  // 833333 Hz per timer count.
  task automatic queue_directed();
    action_q.push_back(rand_item(ACT_TICK));
    action_q.push_back(rand_item(ACT_TICK));
    action_q.push_back(rand_item(ACT_TICK));
    // A period of 1 while the counter sits at 3: the next tick wraps it.
    action_q.push_back(mk_item(ACT_FREQ, '0, 1'b0, 32'd416666));
    action_q.push_back(rand_item(ACT_TICK));
    // A start with no pulses is ignored, then a run of two pulses.
    action_q.push_back(mk_item(ACT_START, 32'd0, 1'b1, '0));
    action_q.push_back(mk_item(ACT_START, 32'd2, 1'b1, '0));
    // A start while busy is ignored.
    action_q.push_back(mk_item(ACT_START, 32'd5, 1'b0, '0));
    repeat (3) action_q.push_back(rand_item(ACT_TICK));
    // Rates too high for one count give a period of zero; a rate of one
    // saturates the period to the counter range.
    action_q.push_back(mk_item(ACT_FREQ, '1, 1'b1, 32'h8000_0000));
    action_q.push_back(mk_item(ACT_FREQ, '0, 1'b0, 32'h7FFF_FFFF));
    action_q.push_back(mk_item(ACT_FREQ, '0, 1'b0, 32'd1));
    action_q.push_back(mk_item(ACT_FREQ, '0, 1'b0, 32'd0 - 32'd83333));
    // Largest count, then a zero rate that halts output but leaves the run
    // busy, so that the next start is ignored until the forced stop.
    action_q.push_back(mk_item(ACT_START, 32'hFFFF_FFFF, 1'b0, '1));
    action_q.push_back(rand_item(ACT_TICK));
    action_q.push_back(mk_item(ACT_FREQ, '1, 1'b1, 32'd0));
    action_q.push_back(mk_item(ACT_START, 32'd3, 1'b1, '0));
    action_q.push_back(rand_item(ACT_TICK));
    action_q.push_back(rand_item(ACT_STOP));
    action_q.push_back(mk_item(ACT_START, 32'd1, 1'b1, '0));
    repeat (5) action_q.push_back(rand_item(ACT_TICK));
  endtask

  // Stimulus: reset once, directed items, then random phases at several
  // prescaler settings with different idling on both sides.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    queue_directed();
    wait_drained();

    write_prescaler(16'd0);
    queue_phase(PHASE_ITEMS, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // The sender keeps offering while the receiver holds off.
    write_prescaler(16'hFFFF);
    queue_phase(PHASE_ITEMS, 1'b0, 1'b1, 1'b1);
    wait_drained();

    write_prescaler(16'($urandom));
    queue_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
    wait_drained();

    write_prescaler(16'd1);
    queue_phase(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
    wait_drained();

    write_prescaler(PRESCALER_RESET);
    queue_phase(PHASE_ITEMS, 1'b0, 1'b1, 1'b0);
    wait_drained();

    // Let a stray late result show up before the verdict.
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    for (int cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/sdpg_pkg.sv
rtl/sdpg_in_if.sv
rtl/sdpg_out_if.sv
rtl/sdpg_period_calc.sv
rtl/step_dir_pulse_train_generator.sv
test/tb.sv
